// ===== rtl/core/splitmix_random_generator_unit_assert.svh =====
// Assertion macros for the random generator unit
`ifndef SPLITMIX_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define SPLITMIX_RANDOM_GENERATOR_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define SRG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define SRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/srg_pkg.sv =====
// Shared types and constants for the random generator unit
`default_nettype none
package srg_pkg;
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
  localparam logic [1:0] OP_RAW = 2'd0;
  localparam logic [1:0] OP_HIGH = 2'd1;
  localparam logic [1:0] OP_BOUND = 2'd2;
  localparam logic [1:0] OP_FRAC = 2'd3;
  typedef struct packed {
    logic [1:0] opcode;
    logic [63:0] bound;
    logic zero_bound;
  } srg_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/splitmix_random_generator_unit.sv =====
// Top level of the SplitMix64 random generator unit
// A raw, upper-half or fraction request is taken from the command queue, then the state is
// advanced and mixed (each 64-bit multiply is built from three 32x32 partial products
// over the mix states) and the result is shaped. A bounded draw first computes the
// threshold remainder, redraws while a sample falls below it, and then computes the final
// remainder, both on the one-bit-per-cycle divider. A zero bound answers with status 1
// and a zero value. After the result transfer the back end returns to idle and then takes
// the next command. Writing seed reloads the state; write it only while idle.
// A two-entry command queue takes requests while a result waits.
`default_nettype none
module splitmix_random_generator_unit #(
  parameter int QueueDepth = 2
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic seed_we,
  input wire logic [63:0] seed,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] opcode,
  input wire logic [63:0] bound,
  output logic out_valid,
  input wire logic out_ready,
  output logic [63:0] sample_value,
  output logic status
);
  logic cmd_valid;
  logic cmd_ready;
  srg_pkg::srg_cmd_t cmd;

  srg_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready), .opcode(opcode),
    .bound(bound), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  srg_back u_back (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_data(seed), .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready), .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready),
    .sample_value(sample_value), .status(status)
  );

`include "splitmix_random_generator_unit_assert.svh"
  `SRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_value))
  `SRG_ASSERT_IMP(a_take_idle, cmd_valid && cmd_ready, !out_valid)
  `SRG_ASSERT_IMP(a_status_zero, out_valid && status, sample_value == 64'd0)
endmodule
`default_nettype wire

// ===== rtl/core/srg_front.sv =====
// Front end: accepts requests, classifies them and queues commands
`default_nettype none
module srg_front #(
  parameter int Depth = 2
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  output logic ready,
  input wire logic [1:0] opcode,
  input wire logic [63:0] bound,
  output logic cmd_valid,
  input wire logic cmd_ready,
  output srg_pkg::srg_cmd_t cmd
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  srg_pkg::srg_cmd_t entries [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic push;
  logic pop;

  assign ready = (count != Depth[AW:0]);
  assign push = valid && ready;
  assign cmd_valid = (count != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{opcode: opcode, bound: bound, zero_bound: (bound == 64'd0)};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/srg_divider.sv =====
// Radix-2 restoring divider, remainder only
`default_nettype none
module srg_divider (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [63:0] dividend,
  input wire logic [63:0] divisor,
  output logic busy,
  output logic done,
  output logic [63:0] remainder
);
  logic [63:0] quo;
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0] cnt;
  logic [64:0] shifted;
  logic [65:0] diff;

  assign shifted = {rem[63:0], quo[63]};
  assign diff = {1'b0, shifted} - {2'b0, dvs};
  assign remainder = rem[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        quo <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        quo <= {quo[62:0], 1'b0};
        rem <= diff[65] ? shifted : diff[64:0];
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/srg_back.sv =====
// Back end: advances the state, mixes samples and shapes the result
`default_nettype none
module srg_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic seed_we,
  input wire logic [63:0] seed_data,
  input wire logic cmd_valid,
  output logic cmd_ready,
  input srg_pkg::srg_cmd_t cmd,
  output logic out_valid,
  input wire logic out_ready,
  output logic [63:0] sample_value,
  output logic status
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_THR = 9'b000000010,
    S_MIX0 = 9'b000000100,
    S_MIX1 = 9'b000001000,
    S_MIX2 = 9'b000010000,
    S_MIX3 = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_MOD = 9'b010000000,
    S_OUT = 9'b100000000
  } state_t;

  state_t st;
  logic [63:0] gen_state;
  logic [63:0] z;
  logic [63:0] threshold;
  srg_pkg::srg_cmd_t cur;
  logic div_start;
  logic [63:0] div_a;
  logic [63:0] div_b;
  logic div_busy;
  logic div_done;
  logic [63:0] div_rem;
  logic [63:0] mix_sum;
  logic [1:0] mstep;
  logic [63:0] acc;
  logic [63:0] mul_k;
  logic [63:0] pp;
  logic [63:0] mul_sum;

  srg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .remainder(div_rem)
  );

  assign cmd_ready = (st == S_IDLE);
  assign out_valid = (st == S_OUT);
  assign mix_sum = gen_state + srg_pkg::GOLDEN_STEP;
  assign mul_sum = acc + {pp[31:0], 32'd0};

  // low half of z times the mix constant, one 32x32 partial product per cycle
  always_comb begin
    mul_k = (st == S_MIX2) ? srg_pkg::MIX_MUL_B : srg_pkg::MIX_MUL_A;
    case (mstep)
      2'd1: pp = {32'd0, z[63:32]} * {32'd0, mul_k[31:0]};
      2'd2: pp = {32'd0, z[31:0]} * {32'd0, mul_k[63:32]};
      default: pp = {32'd0, z[31:0]} * {32'd0, mul_k[31:0]};
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_a = 64'd0 - cur.bound;
    div_b = cur.bound;
    if (st == S_THR && !div_busy && !div_done) begin
      div_start = 1'b1;
    end
    if (st == S_CHECK && cur.opcode == srg_pkg::OP_BOUND && z >= threshold &&
        !div_busy && !div_done) begin
      div_start = 1'b1;
      div_a = z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      gen_state <= 64'd0;
    end else if (seed_we) begin
      gen_state <= seed_data;
    end else begin
      case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            threshold <= '0;
            if (cmd.opcode == srg_pkg::OP_BOUND) begin
              if (cmd.zero_bound) begin
                sample_value <= '0;
                status <= 1'b1;
                st <= S_OUT;
              end else begin
                st <= S_THR;
              end
            end else begin
              st <= S_MIX0;
            end
          end
        end
        S_THR: begin
          if (div_done) begin
            threshold <= div_rem;
            st <= S_MIX0;
          end
        end
        S_MIX0: begin
          gen_state <= mix_sum;
          z <= mix_sum ^ (mix_sum >> 30);
          mstep <= 2'd0;
          st <= S_MIX1;
        end
        S_MIX1: begin
          if (mstep == 2'd0) begin
            acc <= pp;
            mstep <= 2'd1;
          end else if (mstep == 2'd1) begin
            acc <= mul_sum;
            mstep <= 2'd2;
          end else begin
            z <= mul_sum ^ (mul_sum >> 27);
            mstep <= 2'd0;
            st <= S_MIX2;
          end
        end
        S_MIX2: begin
          if (mstep == 2'd0) begin
            acc <= pp;
            mstep <= 2'd1;
          end else if (mstep == 2'd1) begin
            acc <= mul_sum;
            mstep <= 2'd2;
          end else begin
            z <= mul_sum;
            mstep <= 2'd0;
            st <= S_MIX3;
          end
        end
        S_MIX3: begin
          z <= z ^ (z >> 31);
          st <= S_CHECK;
        end
        S_CHECK: begin
          status <= 1'b0;
          case (cur.opcode)
            srg_pkg::OP_RAW: begin
              sample_value <= z;
              st <= S_OUT;
            end
            srg_pkg::OP_HIGH: begin
              sample_value <= {32'd0, z[63:32]};
              st <= S_OUT;
            end
            srg_pkg::OP_FRAC: begin
              sample_value <= {11'd0, z[63:11]};
              st <= S_OUT;
            end
            default: begin
              if (z < threshold) begin
                st <= S_MIX0;
              end else begin
                st <= S_MOD;
              end
            end
          endcase
        end
        S_MOD: begin
          if (div_done) begin
            sample_value <= div_rem;
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_splitmix_random_generator_unit.sv =====
// Self-checking testbench for the SplitMix64 random generator unit
`default_nettype none
module tb_splitmix_random_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] opcode;
    logic [63:0] bound;
    bit known;
    logic [63:0] value;
    logic status;
  } stim_row_t;

  typedef struct {
    logic [63:0] value;
    logic status;
  } draw_result_t;

  logic clk = 0;
  logic rst = 1;
  logic seed_we = 0;
  logic [63:0] seed = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] opcode = srg_pkg::OP_RAW;
  logic [63:0] bound = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] sample_value;
  logic status;

  logic [63:0] gen_state;
  draw_result_t pending_draws[$];
  int mismatch_count = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 80;

  splitmix_random_generator_unit DUT (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed(seed),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .bound(bound),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_value(sample_value), .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] mix_next();
    logic [63:0] z;
    gen_state = gen_state + srg_pkg::GOLDEN_STEP;
    z = gen_state;
    z = (z ^ (z >> 30)) * srg_pkg::MIX_MUL_A;
    z = (z ^ (z >> 27)) * srg_pkg::MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  function automatic draw_result_t predict_draw(logic [1:0] op, logic [63:0] bnd);
    draw_result_t r;
    logic [63:0] thr;
    logic [63:0] s;
    r.value = '0;
    r.status = 1'b0;
    case (op)
      srg_pkg::OP_RAW: r.value = mix_next();
      srg_pkg::OP_HIGH: r.value = mix_next() >> 32;
      srg_pkg::OP_FRAC: r.value = mix_next() >> 11;
      default: begin
        if (bnd == 0) begin
          r.status = 1'b1;
        end else begin
          thr = (64'd0 - bnd) % bnd;
          do s = mix_next(); while (s < thr);
          r.value = s % bnd;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (pending_draws.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transfer: value %h status %b", sample_value, status);
        end else begin
          if (sample_value !== pending_draws[0].value || status !== pending_draws[0].status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h/%b got %h/%b", pending_draws[0].value,
                       pending_draws[0].status, sample_value, status);
          end
          void'(pending_draws.pop_front());
        end
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [63:0] bnd, bit known,
                          logic [63:0] val, logic st);
    draw_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    bound <= bnd;
    r = predict_draw(op, bnd);
    if (known) begin
      r.value = val;
      r.status = st;
    end
    pending_draws.push_back(r);
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_draws.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic load_seed(logic [63:0] v);
    seed_we <= 1'b1;
    seed <= v;
    @(posedge clk);
    seed_we <= 1'b0;
    gen_state = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return 64'd1 + $urandom_range(15);
      2: return {32'd0, $urandom()};
      3: return 64'h8000_0000_0000_0000 + rand64() % 64'h10;
      4: return ~64'd0 - $urandom_range(3);
      default: return rand64();
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{srg_pkg::OP_RAW, 64'd0, 1'b1, 64'he220a8397b1dcdaf, 1'b0},
    '{srg_pkg::OP_HIGH, 64'd0, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_FRAC, 64'd0, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'd0, 1'b1, 64'd0, 1'b1},
    '{srg_pkg::OP_BOUND, 64'd1, 1'b1, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'd2, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'd3, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'h8000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0},
    '{srg_pkg::OP_BOUND, 64'd0, 1'b1, 64'd0, 1'b1},
    '{srg_pkg::OP_RAW, 64'hffff_ffff_ffff_ffff, 1'b0, 64'd0, 1'b0}
  };

  logic [63:0] seed_set[] = '{64'd0, ~64'd0, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000};

  initial begin
    gen_state = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_req(directed[i].opcode, directed[i].bound, directed[i].known,
               directed[i].value, directed[i].status);
    drain_results();
    for (int ph = 0; ph < 4; ph++) begin
      load_seed(ph == 3 ? rand64() : seed_set[ph + 1 < 4 ? ph + 1 : 0]);
      send_idle_pct = ph == 0 ? 26 : (ph == 1 ? 80 : 0);
      recv_idle_pct = ph == 0 ? 80 : (ph == 1 ? 26 : 0);
      for (int n = 0; n < 135; n++) begin
        logic [1:0] op;
        op = $urandom_range(3);
        send_req(op, pick_bound(), 1'b0, '0, 1'b0);
        if (n == 60) drain_results();
      end
      drain_results();
    end
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/srg_pkg.sv
rtl/core/srg_front.sv
rtl/core/srg_divider.sv
rtl/core/srg_back.sv
rtl/core/splitmix_random_generator_unit.sv
dv/tb_splitmix_random_generator_unit.sv
